// File: rtl/osct_pkg.sv
// osct_pkg: shared types and constants of the one-shot compare timer
`default_nettype none
package osct_pkg;

  localparam int COUNT_W    = 32;
  localparam int PRESCALE_W = 16;
  localparam int MASK_W     = 4;
  localparam int CHAN_W     = 2;
  localparam int OP_W       = 2;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [CHAN_W-1:0] TIMEOUT_CHANNEL = 2'd3;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_ARM    = 2'd1,
    OP_CANCEL = 2'd2
  } op_t;

  typedef enum logic {
    REG_PRESCALE = 1'b0,
    REG_RUN      = 1'b1
  } reg_index_t;

  localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = '0;
  localparam logic                  RUN_RESET      = 1'b1;

endpackage
`default_nettype wire

// File: rtl/osct_if.sv
// osct_if: valid/ready channels for input items and result items
`default_nettype none
interface osct_item_if;
  logic                              valid;
  logic                              ready;
  logic [osct_pkg::OP_W-1:0]         op;
  logic [osct_pkg::CHAN_W-1:0]       channel;
  logic [osct_pkg::COUNT_W-1:0]      delay_count;

  modport source (output valid, output op, output channel, output delay_count, input ready);
  modport sink   (input valid, input op, input channel, input delay_count, output ready);
endinterface

interface osct_result_if;
  logic                              valid;
  logic                              ready;
  logic [osct_pkg::COUNT_W-1:0]      count_now;
  logic [osct_pkg::MASK_W-1:0]       fired_mask;
  logic                              timeout_done;

  modport source (output valid, output count_now, output fired_mask, output timeout_done,
                  input ready);
  modport sink   (input valid, input count_now, input fired_mask, input timeout_done,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/one_shot_compare_timer.sv
// one_shot_compare_timer: prescaled 32-bit counter with one-shot compare channels
//
// Takes one item per clock cycle while results are taken and gives one result
// per item, registered in the cycle after the item is accepted. A new item is
// taken in the same cycle the previous result leaves, so items follow back to
// back while results are taken; a stalled result holds the input until it is
// taken. The whole update (prescaler, count increment, channel compares, arm sum)
// is one level of logic between the state registers and the result register.
// Channel 3 is the timeout channel and drives timeout_done.
// Registers: prescale_divide at byte address 0, run_enable at byte address 4.
`default_nettype none
module one_shot_compare_timer #(
  parameter int CHANNELS = 4
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  osct_item_if.sink                             item_in,
  osct_result_if.source                         result_out,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [osct_pkg::ADDR_W-1:0]      paddr,
  input  wire logic [osct_pkg::DATA_W-1:0]      pwdata,
  output logic      [osct_pkg::DATA_W-1:0]      prdata,
  output logic                                  pready
);

  localparam int CW = osct_pkg::COUNT_W;
  localparam int PW = osct_pkg::PRESCALE_W;

  logic [PW-1:0] prescale_divide;
  logic          run_enable;
  logic [PW-1:0] prescale_count;
  logic [PW-1:0] prescale_count_next;
  logic [CW-1:0] main_count;
  logic [CW-1:0] main_count_next;
  logic [CW-1:0] count_inc;
  logic [CW-1:0] arm_delay;
  logic [CW-1:0] arm_value;
  logic          timeout_done_flag;
  logic          timeout_done_next;
  logic          res_valid;
  logic          accept;
  logic          reg_write;
  logic          is_tick;
  logic          is_arm;
  logic          is_cancel;
  logic          advance;
  logic [osct_pkg::MASK_W-1:0] fired;

  logic [CW-1:0] compare_value [CHANNELS];
  logic [CHANNELS-1:0] channel_armed;

  // configuration port
  assign pready    = 1'b1;
  assign reg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_divide <= osct_pkg::PRESCALE_RESET;
      run_enable      <= osct_pkg::RUN_RESET;
    end else if (reg_write) begin
      unique case (osct_pkg::reg_index_t'(paddr[2]))
        osct_pkg::REG_PRESCALE: prescale_divide <= pwdata[PW-1:0];
        osct_pkg::REG_RUN:      run_enable      <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (osct_pkg::reg_index_t'(paddr[2]))
      osct_pkg::REG_PRESCALE: prdata = {{(osct_pkg::DATA_W-PW){1'b0}}, prescale_divide};
      osct_pkg::REG_RUN:      prdata = {{(osct_pkg::DATA_W-1){1'b0}}, run_enable};
    endcase
  end

  // handshake
  assign item_in.ready = ~res_valid | result_out.ready;
  assign accept        = item_in.valid & item_in.ready;

  // operation decode
  always_comb begin
    is_tick   = 1'b0;
    is_arm    = 1'b0;
    is_cancel = 1'b0;
    case (osct_pkg::op_t'(item_in.op))
      osct_pkg::OP_TICK:   is_tick   = 1'b1;
      osct_pkg::OP_ARM:    is_arm    = 1'b1;
      osct_pkg::OP_CANCEL: is_cancel = 1'b1;
      default: ;
    endcase
  end

  assign advance   = is_tick & run_enable & (prescale_count >= prescale_divide);
  assign count_inc = main_count + CW'(1);

  always_comb begin
    prescale_count_next = prescale_count;
    if (is_tick && run_enable) begin
      prescale_count_next = advance ? '0 : prescale_count + PW'(1);
    end
  end

  assign main_count_next = advance ? count_inc : main_count;

  // timeout channel takes a zero delay as one
  assign arm_delay = (item_in.channel == osct_pkg::TIMEOUT_CHANNEL && item_in.delay_count == '0)
                     ? CW'(1) : item_in.delay_count;
  assign arm_value = main_count + arm_delay;

  // compare channels
  for (genvar c = 0; c < osct_pkg::MASK_W; c++) begin : g_chan
    if (c < CHANNELS) begin : g_on
      logic sel;
      assign sel      = item_in.channel == osct_pkg::CHAN_W'(c);
      assign fired[c] = advance & channel_armed[c] & (compare_value[c] == count_inc);

      always_ff @(posedge clk) begin
        if (rst) begin
          compare_value[c] <= '0;
          channel_armed[c] <= 1'b0;
        end else if (accept) begin
          if (fired[c] || (is_cancel && sel)) begin
            channel_armed[c] <= 1'b0;
          end else if (is_arm && sel) begin
            channel_armed[c] <= 1'b1;
          end
          if (is_arm && sel) begin
            compare_value[c] <= arm_value;
          end
        end
      end
    end else begin : g_off
      assign fired[c] = 1'b0;
    end
  end

  always_comb begin
    timeout_done_next = timeout_done_flag;
    if (CHANNELS > int'(osct_pkg::TIMEOUT_CHANNEL)) begin
      if (is_arm && item_in.channel == osct_pkg::TIMEOUT_CHANNEL) begin
        timeout_done_next = 1'b0;
      end else if (fired[osct_pkg::TIMEOUT_CHANNEL]) begin
        timeout_done_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prescale_count    <= '0;
      main_count        <= '0;
      timeout_done_flag <= 1'b0;
    end else if (accept) begin
      prescale_count    <= prescale_count_next;
      main_count        <= main_count_next;
      timeout_done_flag <= timeout_done_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (result_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_out.count_now    <= main_count_next;
      result_out.fired_mask   <= fired;
      result_out.timeout_done <= timeout_done_next;
    end
  end

  assign result_out.valid = res_valid;

endmodule
`default_nettype wire

// File: rtl/osct_checker.sv
// osct_checker: port-level assertions for the one-shot compare timer, with bind
`default_nettype none
module osct_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire logic [osct_pkg::COUNT_W-1:0]   count_now,
  input wire logic [osct_pkg::MASK_W-1:0]    fired_mask,
  input wire logic                           timeout_done
);

  // every accepted item gives a result on the next cycle
  a_item_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item gave no result");

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // a timeout firing always shows done
  a_timeout_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && fired_mask[osct_pkg::TIMEOUT_CHANNEL] |-> timeout_done)
    else $error("timeout fired without done flag");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(count_now) && $stable(fired_mask)
      && $stable(timeout_done))
    else $error("stalled result changed");

endmodule

bind one_shot_compare_timer osct_checker u_osct_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (item_in.valid),
  .in_ready     (item_in.ready),
  .out_valid    (result_out.valid),
  .out_ready    (result_out.ready),
  .count_now    (result_out.count_now),
  .fired_mask   (result_out.fired_mask),
  .timeout_done (result_out.timeout_done)
);
`default_nettype wire

// File: test/testbench.sv
// testbench: table-driven and random items checked against a predictor of the compare timer
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CHANNELS = 4;
  localparam logic [osct_pkg::OP_W-1:0] OP_NONE = 2'd3;
  localparam int DIRECTED_ROWS = 23;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 64;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [osct_pkg::COUNT_W-1:0] count_now;
    logic [osct_pkg::MASK_W-1:0]  fired_mask;
    logic                         timeout_done;
  } timer_reading_t;

  typedef struct packed {
    logic [osct_pkg::OP_W-1:0]    op;
    logic [osct_pkg::CHAN_W-1:0]  channel;
    logic [osct_pkg::COUNT_W-1:0] delay_count;
    logic                         typed;
    timer_reading_t               reading;
  } stim_row_t;

  // typed readings only where the outcome is obvious right after reset
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{osct_pkg::OP_TICK,   2'd0, 32'd0,          1'b1, '{32'd1, 4'h0, 1'b0}},
    '{OP_NONE,             2'd3, 32'hffff_ffff,  1'b1, '{32'd1, 4'h0, 1'b0}},
    '{osct_pkg::OP_ARM,    2'd0, 32'd0,          1'b1, '{32'd1, 4'h0, 1'b0}},
    '{osct_pkg::OP_ARM,    2'd1, 32'd2,          1'b1, '{32'd1, 4'h0, 1'b0}},
    '{osct_pkg::OP_ARM,    2'd3, 32'd0,          1'b1, '{32'd1, 4'h0, 1'b0}},
    '{osct_pkg::OP_TICK,   2'd0, 32'd0,          1'b0, '0},
    '{osct_pkg::OP_TICK,   2'd1, 32'd0,          1'b0, '0},
    '{osct_pkg::OP_ARM,    2'd2, 32'hffff_ffff,  1'b0, '0},
    '{osct_pkg::OP_ARM,    2'd3, 32'd5,          1'b0, '0},
    '{osct_pkg::OP_CANCEL, 2'd3, 32'd0,          1'b0, '0},
    '{osct_pkg::OP_CANCEL, 2'd2, 32'd0,          1'b0, '0},
    '{osct_pkg::OP_ARM,    2'd0, 32'd1,          1'b0, '0},
    '{osct_pkg::OP_ARM,    2'd0, 32'd3,          1'b0, '0},
    '{osct_pkg::OP_TICK,   2'd2, 32'd0,          1'b0, '0},
    '{osct_pkg::OP_TICK,   2'd3, 32'hffff_ffff,  1'b0, '0},
    '{osct_pkg::OP_TICK,   2'd0, 32'd0,          1'b0, '0},
    '{osct_pkg::OP_ARM,    2'd3, 32'd1,          1'b0, '0},
    '{osct_pkg::OP_ARM,    2'd2, 32'd0,          1'b0, '0},
    '{osct_pkg::OP_CANCEL, 2'd1, 32'hffff_ffff,  1'b0, '0},
    '{osct_pkg::OP_TICK,   2'd0, 32'd0,          1'b0, '0},
    '{osct_pkg::OP_ARM,    2'd1, 32'h8000_0000,  1'b0, '0},
    '{OP_NONE,             2'd0, 32'd0,          1'b0, '0},
    '{osct_pkg::OP_TICK,   2'd1, 32'h5555_aaaa,  1'b0, '0}
  };

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [osct_pkg::ADDR_W-1:0]   paddr;
  logic [osct_pkg::DATA_W-1:0]   pwdata;
  logic [osct_pkg::DATA_W-1:0]   prdata;
  logic                          pready;

  osct_item_if   item_ch ();
  osct_result_if result_ch ();

  one_shot_compare_timer #(.CHANNELS(CHANNELS)) uut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_ch),
    .result_out (result_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [osct_pkg::PRESCALE_W-1:0] div_setting = osct_pkg::PRESCALE_RESET;
  logic                            run_setting = osct_pkg::RUN_RESET;
  logic [osct_pkg::PRESCALE_W-1:0] presc_ticks = '0;
  logic [osct_pkg::COUNT_W-1:0]    timer_count = '0;
  logic [osct_pkg::COUNT_W-1:0]    compare_at [CHANNELS] = '{default: '0};
  logic [CHANNELS-1:0]             armed = '0;
  logic                            done_flag = 1'b0;

  timer_reading_t due_readings [$];
  int error_count = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  task automatic flag_error(input string msg);
    if (error_count < REPORT_LIMIT) $display("%0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic step_timer(input logic [osct_pkg::OP_W-1:0] op,
                            input logic [osct_pkg::CHAN_W-1:0] ch,
                            input logic [osct_pkg::COUNT_W-1:0] dly,
                            output timer_reading_t r);
    logic [osct_pkg::MASK_W-1:0]  fired;
    logic [osct_pkg::COUNT_W-1:0] wait_count;
    int                           c;
    fired = '0;
    wait_count = dly;
    if (op == osct_pkg::OP_TICK) begin
      if (run_setting) begin
        if (presc_ticks >= div_setting) begin
          presc_ticks = '0;
          timer_count = timer_count + 1'b1;
          for (c = 0; c < CHANNELS; c++) begin
            if (armed[c] && compare_at[c] == timer_count) begin
              armed[c] = 1'b0;
              fired[c] = 1'b1;
              if (c == osct_pkg::TIMEOUT_CHANNEL) done_flag = 1'b1;
            end
          end
        end else begin
          presc_ticks = presc_ticks + 1'b1;
        end
      end
    end else if (op == osct_pkg::OP_ARM && ch < CHANNELS) begin
      if (ch == osct_pkg::TIMEOUT_CHANNEL) begin
        if (wait_count == '0) wait_count = 1;
        done_flag = 1'b0;
      end
      compare_at[ch] = timer_count + wait_count;
      armed[ch] = 1'b1;
    end else if (op == osct_pkg::OP_CANCEL && ch < CHANNELS) begin
      armed[ch] = 1'b0;
    end
    r = '{timer_count, fired, done_flag};
  endtask

  task automatic send_item(input logic [osct_pkg::OP_W-1:0] op,
                           input logic [osct_pkg::CHAN_W-1:0] ch,
                           input logic [osct_pkg::COUNT_W-1:0] dly, input logic typed,
                           input timer_reading_t typed_reading);
    timer_reading_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.op          <= op;
    item_ch.channel     <= ch;
    item_ch.delay_count <= dly;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    step_timer(op, ch, dly, predicted);
    due_readings.push_back(typed ? typed_reading : predicted);
  endtask

  task automatic write_register(input osct_pkg::reg_index_t idx,
                                input logic [osct_pkg::DATA_W-1:0] value);
    logic [osct_pkg::DATA_W-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx == osct_pkg::REG_PRESCALE) div_setting = value[osct_pkg::PRESCALE_W-1:0];
    else run_setting = value[0];
    @(posedge clk);
    psel   <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (readback !== value)
      flag_error($sformatf("register %s read %h, wrote %h", idx.name(), readback, value));
  endtask

  always @(posedge clk) result_ch.ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    timer_reading_t got;
    timer_reading_t want;
    if (!rst && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
      got = '{result_ch.count_now, result_ch.fired_mask, result_ch.timeout_done};
      if (due_readings.size() == 0) begin
        flag_error($sformatf("result with nothing expected: count %h mask %b done %b",
                             got.count_now, got.fired_mask, got.timeout_done));
      end else begin
        want = due_readings.pop_front();
        if (got.count_now !== want.count_now || got.fired_mask !== want.fired_mask ||
            got.timeout_done !== want.timeout_done)
          flag_error($sformatf("count exp %h got %h, mask exp %b got %b, done exp %b got %b",
                               want.count_now, got.count_now, want.fired_mask,
                               got.fired_mask, want.timeout_done, got.timeout_done));
      end
    end
  end

  logic [osct_pkg::PRESCALE_W-1:0] phase_divide [PHASES] =
    '{16'd0, 16'hffff, 16'd2, 16'd0, 16'd1, 16'd0};
  logic                            phase_run    [PHASES] =
    '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

  initial begin
    int                           p;
    int                           n;
    int                           pick;
    logic [osct_pkg::OP_W-1:0]    op;
    logic [osct_pkg::CHAN_W-1:0]  ch;
    logic [osct_pkg::COUNT_W-1:0] dly;
    rst                 <= 1'b1;
    item_ch.valid       <= 1'b0;
    item_ch.op          <= osct_pkg::OP_TICK;
    item_ch.channel     <= '0;
    item_ch.delay_count <= '0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].channel, directed_rows[i].delay_count,
                directed_rows[i].typed, directed_rows[i].reading);
    item_ch.valid <= 1'b0;

    for (p = 0; p < PHASES; p++) begin
      while (due_readings.size() != 0) @(posedge clk);
      write_register(osct_pkg::REG_PRESCALE, osct_pkg::DATA_W'(phase_divide[p]));
      write_register(osct_pkg::REG_RUN, osct_pkg::DATA_W'(phase_run[p]));
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 55) op = osct_pkg::OP_TICK;
        else if (pick < 80) op = osct_pkg::OP_ARM;
        else if (pick < 92) op = osct_pkg::OP_CANCEL;
        else op = OP_NONE;
        ch = osct_pkg::CHAN_W'($urandom_range(CHANNELS - 1));
        pick = $urandom_range(99);
        if (pick < 70) dly = osct_pkg::COUNT_W'($urandom_range(12));
        else if (pick < 85) dly = $urandom;
        else dly = 32'hffff_ffff - osct_pkg::COUNT_W'($urandom_range(3));
        send_item(op, ch, dly, 1'b0, '0);
      end
      item_ch.valid <= 1'b0;
    end

    while (due_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (error_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
`default_nettype wire
